### rtl/e2c_pkg.sv
`timescale 1ns / 1ps
package e2c_pkg;

   localparam int FACE_SIZE_DEF     = 640;
   localparam int CORDIC_STAGES_DEF = 18;

   localparam int DATA_W  = 35;
   localparam int ANG_W   = 22;
   localparam int POST_W  = 26;
   localparam int FACE_W  = 3;
   localparam int PIX_W   = 12;
   localparam int SW_W    = 14;
   localparam int SH_W    = 13;
   localparam int SX_W    = 21;
   localparam int SY_W    = 20;
   localparam int Q19_W   = 20;
   localparam int KGAIN_W = 20;

   localparam int Q20_ONE     = 1048576;
   localparam int ANG_PI      = 262144;
   localparam int ANG_HALF_PI = 131072;
   localparam int GAIN_K      = 636751;

   localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
   localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_BACK   = 3'd3;
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

   localparam logic REG_SOURCE_WIDTH  = 1'b0;
   localparam logic REG_SOURCE_HEIGHT = 1'b1;

   localparam logic [SW_W-1:0] SOURCE_WIDTH_RST  = 14'd3840;
   localparam logic [SH_W-1:0] SOURCE_HEIGHT_RST = 13'd1920;

   function automatic logic [ANG_W-1:0] atan_entry(input int idx);
      logic [ANG_W-1:0] r;
      case (idx)
         0:  r = 22'd65536;
         1:  r = 22'd38688;
         2:  r = 22'd20442;
         3:  r = 22'd10377;
         4:  r = 22'd5208;
         5:  r = 22'd2607;
         6:  r = 22'd1304;
         7:  r = 22'd652;
         8:  r = 22'd326;
         9:  r = 22'd163;
         10: r = 22'd81;
         11: r = 22'd41;
         12: r = 22'd20;
         13: r = 22'd10;
         14: r = 22'd5;
         15: r = 22'd3;
         16: r = 22'd1;
         17: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/equirect_to_cubemap_coord_map.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                      | payload
// request   | in        | start high, busy low           | req_face, req_pixel_col, req_pixel_row
// response  | out       | rsp_strobe for one cycle       | rsp_source_x, rsp_source_y
// csr       | in/out    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// one request per clock; busy stays low
// requests pass plane registers, first cordic, gain registers, second cordic, output registers
// synchronous reset clears valid bits and loads the csr defaults
// responses cannot be held off, so the pipeline never stalls
module equirect_to_cubemap_coord_map import e2c_pkg::*; #(
   parameter int FACE_SIZE     = FACE_SIZE_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [FACE_W-1:0] req_face,
   input  logic [PIX_W-1:0]  req_pixel_col,
   input  logic [PIX_W-1:0]  req_pixel_row,
   output logic              rsp_strobe,
   output logic [SX_W-1:0]   rsp_source_x,
   output logic [SY_W-1:0]   rsp_source_y,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int SHIFT    = 34;
   localparam int RECIP_W  = 31;
   localparam int PROD_W   = PIX_W + RECIP_W;
   localparam int QUO_W    = PROD_W - (SHIFT - 21);
   localparam int NUM_W    = PIX_W + 22;
   localparam int FS_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / FACE_SIZE);
   localparam logic [FS_W-1:0]    FS    = FS_W'(FACE_SIZE);
   localparam int SIDE1_W  = FACE_W + DATA_W;
   localparam int SIDE2_W  = FACE_W + ANG_W;

   // csr
   logic [SW_W-1:0] src_w_ff;
   logic [SH_W-1:0] src_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SOURCE_WIDTH_RST;
         src_h_ff <= SOURCE_HEIGHT_RST;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[2])
            REG_SOURCE_WIDTH:  src_w_ff <= pwdata[SW_W-1:0];
            REG_SOURCE_HEIGHT: src_h_ff <= pwdata[SH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SOURCE_WIDTH:  prdata = 32'(src_w_ff);
         REG_SOURCE_HEIGHT: prdata = 32'(src_h_ff);
         default:           prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign busy   = 1'b0;

   // plane coordinates: reciprocal multiply with one correction step
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [FACE_W-1:0] face1_ff, face2_ff, face3_ff, face4_ff;
   logic [PIX_W-1:0]  col1_ff, row1_ff, col2_ff, row2_ff;
   logic [PROD_W-1:0] pc2_ff, pr2_ff;
   logic [QUO_W-1:0]  qc3_ff, qr3_ff;
   logic [NUM_W-1:0]  rc3_ff, rr3_ff;
   logic signed [DATA_W-1:0] a4_ff, b4_ff;
   logic [QUO_W-1:0]  qc_e, qr_e;
   logic [QUO_W-1:0]  qc_fix, qr_fix;
   logic [NUM_W-1:0]  rc_fix, rr_fix;
   logic signed [DATA_W-1:0] a4_in, b4_in;

   assign qc_e = QUO_W'(pc2_ff >> (SHIFT - 21));
   assign qr_e = QUO_W'(pr2_ff >> (SHIFT - 21));

   always_comb begin
      qc_fix = qc3_ff;
      rc_fix = rc3_ff;
      if (rc3_ff >= NUM_W'(FS)) begin
         qc_fix = qc3_ff + 1'b1;
         rc_fix = rc3_ff - NUM_W'(FS);
      end
      qr_fix = qr3_ff;
      rr_fix = rr3_ff;
      if (rr3_ff >= NUM_W'(FS)) begin
         qr_fix = qr3_ff + 1'b1;
         rr_fix = rr3_ff - NUM_W'(FS);
      end
      a4_in = $signed(DATA_W'(qc_fix)) - DATA_W'(Q20_ONE)
            + DATA_W'((qc_fix < QUO_W'(Q20_ONE)) && (rc_fix != '0));
      b4_in = $signed(DATA_W'(qr_fix)) - DATA_W'(Q20_ONE)
            + DATA_W'((qr_fix < QUO_W'(Q20_ONE)) && (rr_fix != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      face1_ff <= req_face;
      col1_ff  <= req_pixel_col;
      row1_ff  <= req_pixel_row;
      face2_ff <= face1_ff;
      col2_ff  <= col1_ff;
      row2_ff  <= row1_ff;
      pc2_ff   <= PROD_W'(col1_ff) * PROD_W'(RECIP);
      pr2_ff   <= PROD_W'(row1_ff) * PROD_W'(RECIP);
      face3_ff <= face2_ff;
      qc3_ff   <= qc_e;
      qr3_ff   <= qr_e;
      rc3_ff   <= NUM_W'({col2_ff, 21'b0}) - NUM_W'(qc_e * FS);
      rr3_ff   <= NUM_W'({row2_ff, 21'b0}) - NUM_W'(qr_e * FS);
      face4_ff <= face3_ff;
      a4_ff    <= a4_in;
      b4_ff    <= b4_in;
   end

   // first vectoring pass
   logic pole4;
   logic signed [DATA_W-1:0] c1_x, c1_y;
   logic                     c1_vld;
   logic signed [ANG_W-1:0]  c1_ang;
   logic signed [DATA_W-1:0] c1_mag;
   logic [SIDE1_W-1:0]       c1_side;

   assign pole4 = (face4_ff == FACE_TOP) || (face4_ff == FACE_BOTTOM);
   assign c1_x  = pole4 ? a4_ff : DATA_W'(Q20_ONE);
   assign c1_y  = pole4 ? b4_ff : a4_ff;

   e2c_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (SIDE1_W)
   ) u_cordic1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_x      (c1_x),
      .in_y      (c1_y),
      .in_side   ({face4_ff, b4_ff}),
      .out_valid (c1_vld),
      .out_ang   (c1_ang),
      .out_mag   (c1_mag),
      .out_side  (c1_side)
   );

   // gain correction, split multiply
   localparam int HI_W = DATA_W - 16;
   logic                     g1_vld_ff, g2_vld_ff;
   logic [FACE_W-1:0]        g1_face_ff, g2_face_ff;
   logic signed [DATA_W-1:0] g1_b_ff, g2_b_ff;
   logic signed [ANG_W-1:0]  g1_ang_ff, g2_ang_ff;
   logic [16+KGAIN_W-1:0]    plo_ff;
   logic [HI_W+KGAIN_W-1:0]  phi_ff;
   logic signed [DATA_W-1:0] g2_ff;
   logic [DATA_W-1:0]        mpos;
   logic [56-1:0]            gsum;

   assign mpos = (c1_mag < 0) ? '0 : c1_mag;
   assign gsum = (56'(phi_ff) << 16) + 56'(plo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_vld_ff <= 1'b0;
         g2_vld_ff <= 1'b0;
      end else begin
         g1_vld_ff <= c1_vld;
         g2_vld_ff <= g1_vld_ff;
      end
      g1_face_ff <= c1_side[SIDE1_W-1 -: FACE_W];
      g1_b_ff    <= $signed(c1_side[DATA_W-1:0]);
      g1_ang_ff  <= c1_ang;
      plo_ff     <= (16+KGAIN_W)'(mpos[15:0]) * (16+KGAIN_W)'(GAIN_K);
      phi_ff     <= (HI_W+KGAIN_W)'(mpos[DATA_W-1:16]) * (HI_W+KGAIN_W)'(GAIN_K);
      g2_face_ff <= g1_face_ff;
      g2_b_ff    <= g1_b_ff;
      g2_ang_ff  <= g1_ang_ff;
      g2_ff      <= $signed(DATA_W'(gsum >> 20));
   end

   // second vectoring pass
   logic pole_g;
   logic signed [DATA_W-1:0] c2_x, c2_y;
   logic                     c2_vld;
   logic signed [ANG_W-1:0]  c2_ang;
   logic signed [DATA_W-1:0] c2_mag;
   logic [SIDE2_W-1:0]       c2_side;

   assign pole_g = (g2_face_ff == FACE_TOP) || (g2_face_ff == FACE_BOTTOM);
   assign c2_x   = pole_g ? DATA_W'(Q20_ONE) : g2_ff;
   assign c2_y   = pole_g ? g2_ff : g2_b_ff;

   e2c_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (SIDE2_W)
   ) u_cordic2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g2_vld_ff),
      .in_x      (c2_x),
      .in_y      (c2_y),
      .in_side   ({g2_face_ff, g2_ang_ff}),
      .out_valid (c2_vld),
      .out_ang   (c2_ang),
      .out_mag   (c2_mag),
      .out_side  (c2_side)
   );

   // longitude and latitude, wrap, scale
   logic [FACE_W-1:0]        p_face;
   logic signed [POST_W-1:0] p_ang1, p_t;
   logic signed [POST_W-1:0] u5_in, v5_in;
   logic signed [POST_W-1:0] u5_ff, v5_ff;
   logic                     p1_vld_ff, p2_vld_ff, p3_vld_ff, out_vld_ff;
   logic signed [POST_W-1:0] uw, vw;
   logic [Q19_W-1:0]         qx_in, qy_in, qx_ff, qy_ff;
   logic signed [POST_W-1:0] ux, vy;
   logic [SW_W-1:0]          fx;
   logic [SH_W-1:0]          fy;
   logic [Q19_W+SW_W-1:0]    px_ff;
   logic [Q19_W+SH_W-1:0]    py_ff;
   logic [Q19_W+SW_W-1:0]    rx;
   logic [Q19_W+SH_W-1:0]    ry;
   logic [SX_W-1:0]          sx_ff;
   logic [SY_W-1:0]          sy_ff;

   assign p_face = c2_side[SIDE2_W-1 -: FACE_W];
   assign p_ang1 = POST_W'($signed(c2_side[ANG_W-1:0]));
   assign p_t    = POST_W'(c2_ang);

   always_comb begin
      case (p_face)
         FACE_BOTTOM: begin
            u5_in = p_ang1;
            v5_in = POST_W'(ANG_HALF_PI) - p_t;
         end
         FACE_TOP: begin
            u5_in = -p_ang1;
            v5_in = p_t - POST_W'(ANG_HALF_PI);
         end
         FACE_LEFT: begin
            u5_in = p_ang1 - POST_W'(ANG_HALF_PI);
            v5_in = p_t;
         end
         FACE_RIGHT: begin
            u5_in = p_ang1 + POST_W'(ANG_HALF_PI);
            v5_in = p_t;
         end
         FACE_BACK: begin
            u5_in = p_ang1 + POST_W'(ANG_PI);
            v5_in = p_t;
         end
         default: begin
            u5_in = p_ang1;
            v5_in = p_t;
         end
      endcase
   end

   always_comb begin
      uw = u5_ff;
      vw = v5_ff <<< 1;
      if (vw < -POST_W'(ANG_PI)) begin
         vw = vw + POST_W'(2 * ANG_PI);
         uw = uw + POST_W'(ANG_PI);
      end else if (vw > POST_W'(ANG_PI)) begin
         vw = vw - POST_W'(2 * ANG_PI);
         uw = uw + POST_W'(ANG_PI);
      end
      for (int k = 0; k < 2; k++) begin
         if (uw > POST_W'(ANG_PI)) begin
            uw = uw - POST_W'(2 * ANG_PI);
         end else if (uw < -POST_W'(ANG_PI)) begin
            uw = uw + POST_W'(2 * ANG_PI);
         end
      end
      ux = uw + POST_W'(ANG_PI);
      vy = vw + POST_W'(ANG_PI);
      if (ux < 0) begin
         qx_in = '0;
      end else if (ux > POST_W'(2 * ANG_PI)) begin
         qx_in = Q19_W'(2 * ANG_PI);
      end else begin
         qx_in = ux[Q19_W-1:0];
      end
      if (vy < 0) begin
         qy_in = '0;
      end else if (vy > POST_W'(2 * ANG_PI)) begin
         qy_in = Q19_W'(2 * ANG_PI);
      end else begin
         qy_in = vy[Q19_W-1:0];
      end
   end

   assign fx = (src_w_ff >= SW_W'(1)) ? src_w_ff - 1'b1 : '0;
   assign fy = (src_h_ff >= SH_W'(1)) ? src_h_ff - 1'b1 : '0;
   assign rx = (px_ff + (Q19_W+SW_W)'(1024)) >> 11;
   assign ry = (py_ff + (Q19_W+SH_W)'(1024)) >> 11;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff  <= c2_vld;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         out_vld_ff <= p3_vld_ff;
      end
      u5_ff <= u5_in;
      v5_ff <= v5_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      px_ff <= (Q19_W+SW_W)'(qx_ff) * (Q19_W+SW_W)'(fx);
      py_ff <= (Q19_W+SH_W)'(qy_ff) * (Q19_W+SH_W)'(fy);
      sx_ff <= (rx > (Q19_W+SW_W)'({SX_W{1'b1}})) ? {SX_W{1'b1}} : rx[SX_W-1:0];
      sy_ff <= (ry > (Q19_W+SH_W)'({SY_W{1'b1}})) ? {SY_W{1'b1}} : ry[SY_W-1:0];
   end

   assign rsp_strobe   = out_vld_ff;
   assign rsp_source_x = sx_ff;
   assign rsp_source_y = sy_ff;

endmodule

### rtl/e2c_cordic.sv
`timescale 1ns / 1ps
module e2c_cordic import e2c_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF,
   parameter int SIDE_W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [DATA_W-1:0] in_x,
   input  logic signed [DATA_W-1:0] in_y,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [ANG_W-1:0]  out_ang,
   output logic signed [DATA_W-1:0] out_mag,
   output logic [SIDE_W-1:0]        out_side
);

   logic [STAGES:0]          vld_ff;
   logic signed [DATA_W-1:0] x_ff    [0:STAGES];
   logic signed [DATA_W-1:0] y_ff    [0:STAGES];
   logic signed [ANG_W-1:0]  z_ff    [0:STAGES];
   logic [SIDE_W-1:0]        side_ff [0:STAGES];

   // move left half plane onto the right half
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      side_ff[0] <= in_side;
      if (in_x < 0) begin
         x_ff[0] <= -in_x;
         y_ff[0] <= -in_y;
         z_ff[0] <= (in_y >= 0) ? ANG_W'(ANG_PI) : -ANG_W'(ANG_PI);
      end else begin
         x_ff[0] <= in_x;
         y_ff[0] <= in_y;
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      logic signed [DATA_W-1:0] xs;
      logic signed [DATA_W-1:0] ys;
      logic signed [ANG_W-1:0]  da;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign da = $signed(atan_entry(i));
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         side_ff[i+1] <= side_ff[i];
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + da;
         end else begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - da;
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign out_ang   = z_ff[STAGES];
   assign out_mag   = x_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule
